FILE: rtl/bucketed_linear_probe_hash_index_assert.svh
// Assertion macros used by the checker of this block.
`ifndef BUCKETED_LINEAR_PROBE_HASH_INDEX_ASSERT_SVH
`define BUCKETED_LINEAR_PROBE_HASH_INDEX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLPHI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blphi: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BLPHI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blphi: next-cycle check failed");

`endif

FILE: rtl/blphi_pkg.sv
package blphi_pkg;

	localparam int HOME_ADDRESSES_DEF    = 13;
	localparam int SLOTS_PER_ADDRESS_DEF = 2;
	localparam int KEY_CHARS_DEF         = 7;

	localparam int OFF_W = 32;

	// hash multiplier 31 = 2**5 - 1, applied as shift and subtract
	localparam int HASH_SHIFT = 5;
	localparam int HASH_MULT  = (1 << HASH_SHIFT) - 1;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_FULL = 2'd2,
		STAT_MISS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

FILE: rtl/blphi_mem.sv
module blphi_mem #(
	parameter int DEPTH = 26,
	parameter int DW    = 88,
	localparam int IW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/blphi_hash.sv
module blphi_hash #(
	parameter int HOME_ADDRESSES = blphi_pkg::HOME_ADDRESSES_DEF,
	parameter int KEY_CHARS      = blphi_pkg::KEY_CHARS_DEF,
	localparam int AW            = $clog2(HOME_ADDRESSES),
	localparam int KW            = 8 * KEY_CHARS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [AW-1:0] home
);

	// widest value of sum*31 + byte
	localparam int XW = $clog2(blphi_pkg::HASH_MULT * (HOME_ADDRESSES - 1) + 256);
	localparam logic [XW-1:0] HV = XW'(HOME_ADDRESSES);
	localparam logic [XW-1:0] RV = XW'((2 ** XW) / HOME_ADDRESSES);

	logic          run_q;
	logic          ph_q;
	logic [KW-1:0] key_q;
	logic [AW-1:0] sum_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] q_q;

	logic [7:0]      cur;
	logic            stop;
	logic [XW-1:0]   x_d;
	logic [2*XW-1:0] prod;
	logic [2*XW-1:0] qh;
	logic [XW-1:0]   rem;
	logic [XW-1:0]   rem_fix;

	assign cur  = key_q[KW-1 -: 8];
	// key is zero filled after its end, so a zero byte ends the fold
	assign stop = (cur == 8'd0);

	always_comb begin
		x_d     = (XW'(sum_q) << blphi_pkg::HASH_SHIFT) - XW'(sum_q) + XW'(cur);
		prod    = x_d * RV;
		qh      = q_q * HV;
		rem     = x_q - qh[XW-1:0];
		// quotient estimate is low by at most one
		rem_fix = (rem >= HV) ? (rem - HV) : rem;
	end

	assign done = run_q && !ph_q && stop;
	assign home = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ph_q  <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
			ph_q  <= 1'b0;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			ph_q <= !ph_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			sum_q <= '0;
		end else if (run_q && !ph_q && !stop) begin
			x_q <= x_d;
			q_q <= prod[2*XW-1:XW];
		end else if (run_q && ph_q) begin
			sum_q <= AW'(rem_fix);
			key_q <= key_q << 8;
		end
	end

endmodule

FILE: rtl/bucketed_linear_probe_hash_index.sv
// A request is hashed, then probed slot by slot from its home address until the key is
// found or every slot has been read; the result is registered and shown with done.
// The hash unit folds the key one byte at a time; the probe reads one slot per cycle.
// A new request can be taken in the done cycle.
// Asynchronous active-low reset empties the table (all slot valid bits clear) and idles.
module bucketed_linear_probe_hash_index #(
	parameter int HOME_ADDRESSES    = blphi_pkg::HOME_ADDRESSES_DEF,
	parameter int SLOTS_PER_ADDRESS = blphi_pkg::SLOTS_PER_ADDRESS_DEF,
	parameter int KEY_CHARS         = blphi_pkg::KEY_CHARS_DEF,
	localparam int KW = 8 * KEY_CHARS,
	localparam int AW = $clog2(HOME_ADDRESSES),
	localparam int SW = (SLOTS_PER_ADDRESS > 1) ? $clog2(SLOTS_PER_ADDRESS) : 1,
	localparam int NS = HOME_ADDRESSES * SLOTS_PER_ADDRESS,
	localparam int TW = $clog2(HOME_ADDRESSES + 1),
	localparam int CW = $clog2(NS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [KW-1:0]              key,
	input  logic [blphi_pkg::OFF_W-1:0] record_offset,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [AW-1:0]              home_address,
	output logic [AW-1:0]              hit_address,
	output logic [SW-1:0]              hit_slot,
	output logic [TW-1:0]              attempt,
	output logic [CW-1:0]              accesses,
	output logic [blphi_pkg::OFF_W-1:0] found_offset
);

	localparam int OW = blphi_pkg::OFF_W;
	localparam int IW = $clog2(NS);
	localparam int DW = KW + OW;

	blphi_pkg::state_t state_q, state_d;

	logic [1:0]    act_q;
	logic [KW-1:0] key_q;
	logic [OW-1:0] off_q;
	logic [AW-1:0] home_q;

	// probe issue counters
	logic [IW-1:0] idx_q;
	logic [AW-1:0] addr_q;
	logic [SW-1:0] slot_q;
	logic [TW-1:0] att_q;
	logic [CW-1:0] issue_q;

	// compare stage, aligned with the memory read data
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [AW-1:0] addr_s1;
	logic [SW-1:0] slot_s1;
	logic [TW-1:0] att_s1;
	logic [CW-1:0] seq_s1;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [AW-1:0] hit_addr_q;
	logic [SW-1:0] hit_slot_q;
	logic [CW-1:0] hit_cnt_q;
	logic [OW-1:0] hit_off_q;

	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [AW-1:0] free_addr_q;
	logic [SW-1:0] free_slot_q;
	logic [TW-1:0] free_att_q;

	logic [NS-1:0] valid_q;

	logic                done_q;
	blphi_pkg::status_t  status_q;
	logic [AW-1:0]       home_out_q;
	logic [AW-1:0]       hit_addr_out_q;
	logic [SW-1:0]       hit_slot_out_q;
	logic [TW-1:0]       att_out_q;
	logic [CW-1:0]       acc_out_q;
	logic [OW-1:0]       off_out_q;

	blphi_pkg::status_t  status_d;
	logic [AW-1:0]       hit_addr_d;
	logic [SW-1:0]       hit_slot_d;
	logic [TW-1:0]       att_d;
	logic [CW-1:0]       acc_d;
	logic [OW-1:0]       off_d;

	logic          accept;
	logic [KW-1:0] key_norm;
	logic          hash_done;
	logic [AW-1:0] hash_home;
	logic          issue_en;
	logic [DW-1:0] rd_data;
	logic [KW-1:0] rd_key;
	logic          slot_live;
	logic          hit_now;
	logic          free_now;
	logic          last_now;
	logic          ins_write;
	logic          rem_clear;

	function automatic logic [KW-1:0] norm_key(input logic [KW-1:0] k);
		logic [KW-1:0] r;
		logic          live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (k[KW-1-8*i -: 8] == 8'd0) live = 1'b0;
			if (live) r[KW-1-8*i -: 8] = k[KW-1-8*i -: 8];
		end
		return r;
	endfunction

	assign accept   = start && (state_q == blphi_pkg::ST_IDLE);
	assign busy     = (state_q != blphi_pkg::ST_IDLE);
	assign key_norm = norm_key(key);

	blphi_hash #(
		.HOME_ADDRESSES(HOME_ADDRESSES),
		.KEY_CHARS(KEY_CHARS)
	) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.key(key_norm),
		.done(hash_done),
		.home(hash_home)
	);

	assign issue_en  = (state_q == blphi_pkg::ST_SCAN) && (issue_q != CW'(NS));
	assign ins_write = (state_q == blphi_pkg::ST_FIN) && (act_q == blphi_pkg::ACT_INSERT) &&
		!hit_q && free_q;
	assign rem_clear = (state_q == blphi_pkg::ST_FIN) && (act_q == blphi_pkg::ACT_REMOVE) &&
		hit_q;

	blphi_mem #(
		.DEPTH(NS),
		.DW(DW)
	) u_mem (
		.clk(clk),
		.we(ins_write),
		.waddr(free_idx_q),
		.wdata({key_q, off_q}),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign rd_key    = rd_data[DW-1 -: KW];
	assign slot_live = valid_q[idx_s1];
	assign hit_now   = vld_s1 && slot_live && (rd_key == key_q);
	// first empty slot in probe order is where an insert lands
	assign free_now  = vld_s1 && !slot_live && !free_q;
	assign last_now  = vld_s1 && (seq_s1 == CW'(NS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blphi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blphi_pkg::ST_IDLE: begin
				if (start) state_d = blphi_pkg::ST_HASH;
			end
			blphi_pkg::ST_HASH: begin
				if (hash_done) state_d = blphi_pkg::ST_SCAN;
			end
			blphi_pkg::ST_SCAN: begin
				if (hit_now || last_now) state_d = blphi_pkg::ST_FIN;
			end
			blphi_pkg::ST_FIN: begin
				state_d = blphi_pkg::ST_IDLE;
			end
			default: state_d = blphi_pkg::ST_IDLE;
		endcase
	end

	// sequencer counters, compare stage, table valid bits and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= issue_en;
			done_q <= (state_q == blphi_pkg::ST_FIN);
			if (state_q == blphi_pkg::ST_HASH) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end
			if (issue_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if (state_q == blphi_pkg::ST_SCAN) begin
				if (hit_now) hit_q <= 1'b1;
				if (free_now) free_q <= 1'b1;
			end
			if (ins_write) valid_q[free_idx_q] <= 1'b1;
			if (rem_clear) valid_q[hit_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key_norm;
			off_q <= record_offset;
		end
		if (state_q == blphi_pkg::ST_HASH) begin
			home_q <= hash_home;
			idx_q  <= IW'(hash_home * SLOTS_PER_ADDRESS);
			addr_q <= hash_home;
			slot_q <= '0;
			att_q  <= TW'(1);
		end
		if (issue_en) begin
			idx_q <= (idx_q == IW'(NS - 1)) ? '0 : idx_q + IW'(1);
			if (slot_q == SW'(SLOTS_PER_ADDRESS - 1)) begin
				slot_q <= '0;
				addr_q <= (addr_q == AW'(HOME_ADDRESSES - 1)) ? '0 : addr_q + AW'(1);
				att_q  <= att_q + TW'(1);
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
		idx_s1  <= idx_q;
		addr_s1 <= addr_q;
		slot_s1 <= slot_q;
		att_s1  <= att_q;
		seq_s1  <= issue_q + CW'(1);
		if ((state_q == blphi_pkg::ST_SCAN) && hit_now) begin
			hit_idx_q  <= idx_s1;
			hit_addr_q <= addr_s1;
			hit_slot_q <= slot_s1;
			hit_cnt_q  <= seq_s1;
			hit_off_q  <= rd_data[OW-1:0];
		end
		if ((state_q == blphi_pkg::ST_SCAN) && free_now) begin
			free_idx_q  <= idx_s1;
			free_addr_q <= addr_s1;
			free_slot_q <= slot_s1;
			free_att_q  <= att_s1;
		end
	end

	// pick the result fields for the finished request
	always_comb begin
		status_d   = blphi_pkg::STAT_OK;
		hit_addr_d = '0;
		hit_slot_d = '0;
		att_d      = '0;
		acc_d      = '0;
		off_d      = '0;
		case (act_q)
			blphi_pkg::ACT_INSERT: begin
				if (hit_q) begin
					status_d   = blphi_pkg::STAT_DUP;
					hit_addr_d = hit_addr_q;
					hit_slot_d = hit_slot_q;
				end else if (free_q) begin
					hit_addr_d = free_addr_q;
					hit_slot_d = free_slot_q;
					att_d      = free_att_q;
				end else begin
					status_d = blphi_pkg::STAT_FULL;
				end
			end
			blphi_pkg::ACT_SEARCH: begin
				if (hit_q) begin
					hit_addr_d = hit_addr_q;
					hit_slot_d = hit_slot_q;
					acc_d      = hit_cnt_q;
					off_d      = hit_off_q;
				end else begin
					status_d = blphi_pkg::STAT_MISS;
				end
			end
			blphi_pkg::ACT_REMOVE: begin
				if (hit_q) begin
					hit_addr_d = hit_addr_q;
					hit_slot_d = hit_slot_q;
				end else begin
					status_d = blphi_pkg::STAT_MISS;
				end
			end
			default: ;
		endcase
	end

	// result register, loaded in the finish cycle
	always_ff @(posedge clk) begin
		if (state_q == blphi_pkg::ST_FIN) begin
			status_q       <= status_d;
			home_out_q     <= home_q;
			hit_addr_out_q <= hit_addr_d;
			hit_slot_out_q <= hit_slot_d;
			att_out_q      <= att_d;
			acc_out_q      <= acc_d;
			off_out_q      <= off_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign home_address = home_out_q;
	assign hit_address  = hit_addr_out_q;
	assign hit_slot     = hit_slot_out_q;
	assign attempt      = att_out_q;
	assign accesses     = acc_out_q;
	assign found_offset = off_out_q;

endmodule

FILE: rtl/blphi_checker.sv
`include "bucketed_linear_probe_hash_index_assert.svh"

module blphi_checker #(
	parameter int HOME_ADDRESSES    = blphi_pkg::HOME_ADDRESSES_DEF,
	parameter int SLOTS_PER_ADDRESS = blphi_pkg::SLOTS_PER_ADDRESS_DEF,
	localparam int AW = $clog2(HOME_ADDRESSES),
	localparam int SW = (SLOTS_PER_ADDRESS > 1) ? $clog2(SLOTS_PER_ADDRESS) : 1,
	localparam int TW = $clog2(HOME_ADDRESSES + 1),
	localparam int CW = $clog2(HOME_ADDRESSES * SLOTS_PER_ADDRESS + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [AW-1:0]               home_address,
	input logic [AW-1:0]               hit_address,
	input logic [SW-1:0]               hit_slot,
	input logic [TW-1:0]               attempt,
	input logic [CW-1:0]               accesses,
	input logic [blphi_pkg::OFF_W-1:0] found_offset
);

	logic full_res;
	logic fail_res;
	logic hit_clear;
	logic data_clear;

	assign full_res   = done && (status == blphi_pkg::STAT_FULL);
	assign fail_res   = done && (status != blphi_pkg::STAT_OK);
	assign hit_clear  = (hit_address == '0) && (hit_slot == '0) && (attempt == '0);
	assign data_clear = (accesses == '0) && (found_offset == '0);

	// an accepted request makes the block busy
	`BLPHI_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// result shows up only once the sequencer is back to idle
	`BLPHI_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)

	`BLPHI_ASSERT_NOW(a_home_range, clk, arst_n, done, home_address < AW'(HOME_ADDRESSES))

	`BLPHI_ASSERT_NOW(a_full_clear, clk, arst_n, full_res, hit_clear)

	`BLPHI_ASSERT_NOW(a_fail_no_data, clk, arst_n, fail_res, data_clear)

endmodule

bind bucketed_linear_probe_hash_index blphi_checker #(
	.HOME_ADDRESSES(HOME_ADDRESSES),
	.SLOTS_PER_ADDRESS(SLOTS_PER_ADDRESS)
) u_blphi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.home_address(home_address),
	.hit_address(hit_address),
	.hit_slot(hit_slot),
	.attempt(attempt),
	.accesses(accesses),
	.found_offset(found_offset)
);

FILE: tb/sv/bucketed_linear_probe_hash_index_test.sv
`timescale 1ns / 100ps

module bucketed_linear_probe_hash_index_test;
	import blphi_pkg::*;

	localparam int HOMES       = HOME_ADDRESSES_DEF;
	localparam int SLOTS       = SLOTS_PER_ADDRESS_DEF;
	localparam int TABLE_SLOTS = HOMES * SLOTS;
	localparam int KEY_BYTES   = KEY_CHARS_DEF;
	localparam int KEY_W       = 8 * KEY_BYTES;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		status_t      status;
		logic [3:0]   home_address;
		logic [3:0]   hit_address;
		logic         hit_slot;
		logic [3:0]   attempt;
		logic [4:0]   accesses;
		logic [31:0]  found_offset;
	} index_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [KEY_W-1:0]   key;
	logic [31:0]        record_offset;
	logic               done;
	logic [1:0]         status;
	logic [3:0]         home_address;
	logic [3:0]         hit_address;
	logic [0:0]         hit_slot;
	logic [3:0]         attempt;
	logic [4:0]         accesses;
	logic [31:0]        found_offset;

	// shadow copy of the index
	bit                 table_used [TABLE_SLOTS];
	logic [KEY_W-1:0]   table_key [TABLE_SLOTS];
	logic [31:0]        table_offset [TABLE_SLOTS];

	index_result_t      pending_results [$];
	status_t            last_status;
	int                 status_count [4];
	int                 requests_sent;
	int                 results_checked;
	int                 mismatches;
	int                 cycle_count;
	bit                 burst_mode;

	bucketed_linear_probe_hash_index uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.key           (key),
		.record_offset (record_offset),
		.done          (done),
		.status        (status),
		.home_address  (home_address),
		.hit_address   (hit_address),
		.hit_slot      (hit_slot),
		.attempt       (attempt),
		.accesses      (accesses),
		.found_offset  (found_offset)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drop every byte after the first zero byte
	function automatic logic [KEY_W-1:0] key_canonical(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		int i;
		k = '0;
		for (i = 0; i < KEY_BYTES; i++) begin
			if (raw[KEY_W-1-8*i -: 8] == 8'd0)
				break;
			k[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
		end
		return k;
	endfunction

	function automatic int key_home(input logic [KEY_W-1:0] k);
		int sum;
		int i;
		sum = 0;
		for (i = 0; i < KEY_BYTES; i++) begin
			if (k[KEY_W-1-8*i -: 8] == 8'd0)
				break;
			sum = (sum * 31 + int'(k[KEY_W-1-8*i -: 8])) % HOMES;
		end
		return sum;
	endfunction

	function automatic bit probe_for_key(input logic [KEY_W-1:0] k, input int home,
			output int hit_a, output int hit_s, output int probes);
		int addr;
		int t;
		int j;
		addr = home;
		probes = 0;
		hit_a = 0;
		hit_s = 0;
		for (t = 0; t < HOMES; t++) begin
			for (j = 0; j < SLOTS; j++) begin
				probes++;
				if (table_used[addr*SLOTS+j] && table_key[addr*SLOTS+j] == k) begin
					hit_a = addr;
					hit_s = j;
					return 1'b1;
				end
			end
			addr = (addr + 1) % HOMES;
		end
		return 1'b0;
	endfunction

	// apply one request to the shadow index and return its result
	function automatic index_result_t index_apply(input logic [1:0] act,
			input logic [KEY_W-1:0] raw_key, input logic [31:0] off);
		index_result_t r;
		logic [KEY_W-1:0] k;
		int home;
		int hit_a;
		int hit_s;
		int probes;
		int addr;
		int idx;
		int t;
		int j;
		bit hit;
		bit placed;
		k = key_canonical(raw_key);
		home = key_home(k);
		r.status = STAT_OK;
		r.home_address = 4'(home);
		r.hit_address = '0;
		r.hit_slot = 1'b0;
		r.attempt = '0;
		r.accesses = '0;
		r.found_offset = '0;
		hit = probe_for_key(k, home, hit_a, hit_s, probes);
		case (act)
		ACT_INSERT: begin
			if (hit) begin
				r.status = STAT_DUP;
				r.hit_address = 4'(hit_a);
				r.hit_slot = 1'(hit_s);
			end else begin
				placed = 1'b0;
				addr = home;
				for (t = 1; t <= HOMES && !placed; t++) begin
					for (j = 0; j < SLOTS && !placed; j++) begin
						idx = addr * SLOTS + j;
						if (!table_used[idx]) begin
							table_used[idx] = 1'b1;
							table_key[idx] = k;
							table_offset[idx] = off;
							r.hit_address = 4'(addr);
							r.hit_slot = 1'(j);
							r.attempt = 4'(t);
							placed = 1'b1;
						end
					end
					addr = (addr + 1) % HOMES;
				end
				if (!placed)
					r.status = STAT_FULL;
			end
		end
		ACT_SEARCH: begin
			if (hit) begin
				r.hit_address = 4'(hit_a);
				r.hit_slot = 1'(hit_s);
				r.accesses = 5'(probes);
				r.found_offset = table_offset[hit_a*SLOTS+hit_s];
			end else begin
				r.status = STAT_MISS;
			end
		end
		ACT_REMOVE: begin
			if (hit) begin
				table_used[hit_a*SLOTS+hit_s] = 1'b0;
				r.hit_address = 4'(hit_a);
				r.hit_slot = 1'(hit_s);
			end else begin
				r.status = STAT_MISS;
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(input logic [1:0] act, input logic [KEY_W-1:0] k,
			input logic [31:0] off);
		index_result_t r;
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			// half the time count the gap from the end of the previous request
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (busy !== 1'b0);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		key <= k;
		record_offset <= off;
		do @(posedge clk); while (busy !== 1'b0);
		r = index_apply(act, k, off);
		pending_results.push_back(r);
		last_status = r.status;
		status_count[r.status]++;
		requests_sent++;
	endtask

	always @(posedge clk) begin
		index_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", 64'(status), 64'd0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (home_address !== want.home_address)
					report_mismatch("home_address", 64'(home_address), 64'(want.home_address));
				if (hit_address !== want.hit_address)
					report_mismatch("hit_address", 64'(hit_address), 64'(want.hit_address));
				if (hit_slot !== want.hit_slot)
					report_mismatch("hit_slot", 64'(hit_slot), 64'(want.hit_slot));
				if (attempt !== want.attempt)
					report_mismatch("attempt", 64'(attempt), 64'(want.attempt));
				if (accesses !== want.accesses)
					report_mismatch("accesses", 64'(accesses), 64'(want.accesses));
				if (found_offset !== want.found_offset)
					report_mismatch("found_offset", 64'(found_offset), 64'(want.found_offset));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("bucketed_linear_probe_hash_index_test: errors");
			$finish;
		end
	end

	// empty table misses, key extremes, ignored trailing bytes, collisions and wrap
	task automatic test_basic_ops();
		send_request(ACT_SEARCH, 56'h41000000000000, 32'h0);
		send_request(ACT_REMOVE, 56'h41000000000000, 32'h0);
		send_request(ACT_INSERT, 56'hFFFFFFFFFFFFFF, 32'hFFFFFFFF);
		send_request(ACT_INSERT, 56'h00FFFFFFFFFFFF, 32'h00000000);
		send_request(ACT_INSERT, 56'h4142005A5A5A5A, 32'h12345678);
		send_request(ACT_INSERT, 56'h41420000000000, 32'h00000001);
		send_request(ACT_INSERT, 56'h00000000000000, 32'h00000002);
		send_request(ACT_SEARCH, 56'h41420033000000, 32'h0);
		send_request(ACT_SEARCH, 56'hFFFFFFFFFFFFFF, 32'h0);
		send_request(ACT_SEARCH, 56'h00000000000000, 32'h0);
		send_request(ACT_UNUSED, 56'hFFFFFFFFFFFFFF, 32'hFFFFFFFF);
		// 'A', 'N' and '[' share home address zero with the empty key
		send_request(ACT_INSERT, 56'h41000000000000, 32'hA5A5A5A5);
		send_request(ACT_INSERT, 56'h4E000000000000, 32'h5A5A5A5A);
		send_request(ACT_INSERT, 56'h5B000000000000, 32'h0000FFFF);
		// 'M', 'Z' and 'g' hash to the last address, the third one wraps
		send_request(ACT_INSERT, 56'h4D000000000000, 32'hFFFF0000);
		send_request(ACT_INSERT, 56'h5A000000000000, 32'h01010101);
		send_request(ACT_INSERT, 56'h67000000000000, 32'h80000000);
		send_request(ACT_SEARCH, 56'h67000000000000, 32'h0);
		send_request(ACT_SEARCH, 56'h5B000000000000, 32'h0);
		send_request(ACT_REMOVE, 56'h4E000000000000, 32'h0);
		send_request(ACT_SEARCH, 56'h5B000000000000, 32'h0);
		send_request(ACT_INSERT, 56'h4E000000000000, 32'h7FFFFFFF);
		send_request(ACT_REMOVE, 56'h00121212121212, 32'h0);
		send_request(ACT_SEARCH, 56'h00000000000000, 32'h0);
		send_request(ACT_REMOVE, 56'hFFFFFFFFFFFFFF, 32'h0);
		send_request(ACT_INSERT, 56'h01020304050607, 32'hDEADBEEF);
	endtask

	// fill every free slot, overflow twice with the same key, then clear what was added
	task automatic test_table_full();
		int i;
		int n;
		n = 0;
		do begin
			send_request(ACT_INSERT, {8'h71, 8'(8'h30 + n), 40'h0}, $urandom);
			n++;
		end while (last_status != STAT_FULL && n < 2 * TABLE_SLOTS);
		send_request(ACT_INSERT, {8'h71, 8'(8'h30 + n - 1), 40'h0}, $urandom);
		send_request(ACT_SEARCH, {8'h71, 8'h30, 40'h0}, 32'h0);
		send_request(ACT_SEARCH, {8'h71, 8'(8'h30 + n - 2), 40'h0}, 32'h0);
		for (i = n - 1; i >= 0; i--)
			send_request(ACT_REMOVE, {8'h71, 8'(8'h30 + i), 40'h0}, 32'h0);
	endtask

	// mostly keys from a small pool so inserts, hits, removals and overflow recur
	task automatic test_random_traffic(input int total);
		logic [KEY_W-1:0] pool [40];
		logic [KEY_W-1:0] k;
		logic [1:0] act;
		int len;
		int i;
		int n;
		int r;
		int ins_w;
		int rem_w;
		for (i = 0; i < 40; i++) begin
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, KEY_BYTES);
			k = '0;
			for (n = 0; n < len; n++)
				k[KEY_W-1-8*n -: 8] = 8'($urandom_range(1, 255));
			pool[i] = k;
		end
		ins_w = 40;
		rem_w = 20;
		for (i = 0; i < total; i++) begin
			if (i % 50 == 0) begin
				ins_w = $urandom_range(20, 60);
				rem_w = $urandom_range(10, 35);
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				k[KEY_W-1:32] = 24'($urandom);
				k[31:0] = $urandom;
			end else begin
				k = pool[$urandom_range(0, 39)];
				// bytes past the terminator must not change the key
				if ($urandom_range(0, 3) == 0) begin
					len = 0;
					while (len < KEY_BYTES && k[KEY_W-1-8*len -: 8] != 8'd0)
						len++;
					for (n = len + 1; n < KEY_BYTES; n++)
						k[KEY_W-1-8*n -: 8] = 8'($urandom);
				end
			end
			r = $urandom_range(0, 99);
			if (r < ins_w)
				act = ACT_INSERT;
			else if (r < ins_w + rem_w)
				act = ACT_REMOVE;
			else if (r < 97)
				act = ACT_SEARCH;
			else
				act = ACT_UNUSED;
			send_request(act, k, $urandom);
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_INSERT;
		key <= '0;
		record_offset <= '0;
		burst_mode = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_table_full();
		test_random_traffic(580);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d requests, %0d results checked, %0d mismatches", requests_sent,
			results_checked, mismatches);
		$display("done/found %0d, duplicate %0d, table full %0d, not found %0d",
			status_count[STAT_OK], status_count[STAT_DUP], status_count[STAT_FULL],
			status_count[STAT_MISS]);
		if (mismatches == 0)
			$display("bucketed_linear_probe_hash_index_test: clean");
		else
			$display("bucketed_linear_probe_hash_index_test: errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/blphi_pkg.sv
rtl/blphi_mem.sv
rtl/blphi_hash.sv
rtl/bucketed_linear_probe_hash_index.sv
rtl/blphi_checker.sv
tb/sv/bucketed_linear_probe_hash_index_test.sv
